@@ rtl/core/rtc_calendar_with_alarm_defines.svh @@
// Assertion macros for the RTC calendar RTL, used by rtc_engine.
`ifndef RTC_CALENDAR_WITH_ALARM_DEFINES_SVH
`define RTC_CALENDAR_WITH_ALARM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rtc_pkg.sv @@
// Shared types and constants for the RTC calendar with alarm.
package rtc_pkg;

  localparam int unsigned DEF_TICKS_PER_SECOND = 1000;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
  localparam logic [5:0]  MINS_PER_HOUR   = 6'd60;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic [4:0]  DAY_LEAP_FEB    = 5'd29;
  localparam logic [4:0]  DAY_PLAIN_FEB   = 5'd28;
  localparam logic [15:0] YEAR_STEP_MAX   = 16'd2099;

  localparam logic [15:0] RST_YEAR = 16'd2025;
  localparam logic [4:0]  RST_HOUR = 5'd12;
  localparam logic [4:0]  RST_ALARM_HOUR = 5'd7;

  typedef enum logic [3:0] {
    KIND_TICK       = 4'd0,
    KIND_SET_TIME   = 4'd1,
    KIND_SET_DATE   = 4'd2,
    KIND_STEP_HOUR  = 4'd3,
    KIND_STEP_MIN   = 4'd4,
    KIND_STEP_DAY   = 4'd5,
    KIND_STEP_MONTH = 4'd6,
    KIND_STEP_YEAR  = 4'd7,
    KIND_PAUSE      = 4'd8,
    KIND_RESUME     = 4'd9,
    KIND_ACK        = 4'd10,
    KIND_DISMISS    = 4'd11,
    KIND_RESTART    = 4'd12
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALARM_HOUR   = 2'd0,
    CFG_ALARM_MINUTE = 2'd1,
    CFG_ALARM_ENABLE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  new_hour;
    logic [7:0]  new_minute;
    logic [7:0]  new_day;
    logic [7:0]  new_month;
    logic [15:0] new_year;
    logic [3:0]  ack_mask;
  } item_t;

  typedef struct packed {
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [15:0] year_now;
    logic        hours_changed;
    logic        minutes_changed;
    logic        date_changed;
    logic        alarm_fired;
    logic        is_paused;
  } status_t;

endpackage

@@ rtl/core/rtc_in_stage.sv @@
// Input register stage: captures one request and holds it until the engine takes it.
module rtc_in_stage import rtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // new_hour, new_minute, new_day, new_month,
                                           // new_year, ack_mask, zero pad
  input  logic [IN_TUSER_W-1:0] in_tuser,  // kind
  input  logic                  take,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  item_t item_r;
  logic  accept;

  assign in_tready  = !valid_r || take;
  assign accept     = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind       <= kind_t'(in_tuser);
      item_r.new_hour   <= in_tdata[7:0];
      item_r.new_minute <= in_tdata[15:8];
      item_r.new_day    <= in_tdata[23:16];
      item_r.new_month  <= in_tdata[31:24];
      item_r.new_year   <= in_tdata[47:32];
      item_r.ack_mask   <= in_tdata[51:48];
    end
  end

endmodule

@@ rtl/core/rtc_engine.sv @@
// Time, date, alarm and flag state with the per-request update logic.
`include "rtc_calendar_with_alarm_defines.svh"

module rtc_engine import rtc_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  item_t                 item,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output status_t               status_nxt
);

  localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SUB_W:0] TPS = (SUB_W+1)'(TICKS_PER_SECOND);
  // 25 * INV25 == 1 mod 2^16; y divisible by 25 iff y*INV25 mod 2^16 <= 65535/25
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [5:0]       sec_r, sec_nxt;
  logic [5:0]       min_r, min_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [4:0]       day_r, day_nxt;
  logic [3:0]       mon_r, mon_nxt;
  logic [15:0]      year_r, year_nxt;
  logic             leap_r, leap_nxt;
  logic [2:0]       chg_r, chg_nxt;
  logic             fired_r, fired_nxt;
  logic             armed_r, armed_nxt;
  logic             paused_r, paused_nxt;

  logic [4:0]       alm_hour_r;
  logic [5:0]       alm_min_r;
  logic             alm_en_r;

  logic [SUB_W:0]   sub_wide;
  logic [15:0]      year_cand;
  logic             leap_cand;
  logic             year_step_ok;
  logic [15:0]      year_step;
  logic             leap_step;
  logic [4:0]       md_cur;

  function automatic logic is_leap(logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic lp);
    logic [4:0] d;
    case (m) inside
      4'd2:                                d = lp ? DAY_LEAP_FEB : DAY_PLAIN_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:             d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                               d = 5'd31;
      default:                             d = 5'd30;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] mod_hours(logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int i = 3; i >= 0; i--) begin
      if (r >= (8'(HOURS_PER_DAY) << i)) r = r - (8'(HOURS_PER_DAY) << i);
    end
    return r[4:0];
  endfunction

  function automatic logic [5:0] mod_minutes(logic [7:0] v);
    logic [7:0] r;
    r = v;
    for (int i = 2; i >= 0; i--) begin
      if (r >= (8'(MINS_PER_HOUR) << i)) r = r - (8'(MINS_PER_HOUR) << i);
    end
    return r[5:0];
  endfunction

  // One leap evaluation shared by set date, step year and the year rollover.
  assign year_cand    = (item.kind == KIND_SET_DATE) ? item.new_year : year_r + 16'd1;
  assign leap_cand    = is_leap(year_cand);
  assign year_step_ok = (year_r < YEAR_STEP_MAX);
  assign year_step    = year_step_ok ? year_r + 16'd1 : year_r;
  assign leap_step    = year_step_ok ? leap_cand : leap_r;
  assign sub_wide     = {1'b0, sub_r} + {{SUB_W{1'b0}}, 1'b1};
  assign md_cur       = month_days(mon_r, leap_r);

  always_comb begin
    logic [3:0] m_set;
    logic [4:0] md_set;
    logic [3:0] m_step;
    logic [4:0] md_step;
    logic       match;
    logic       armed_tmp;

    sub_nxt    = sub_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    year_nxt   = year_r;
    leap_nxt   = leap_r;
    chg_nxt    = chg_r;
    fired_nxt  = fired_r;
    armed_nxt  = armed_r;
    paused_nxt = paused_r;
    match      = 1'b0;
    armed_tmp  = armed_r;

    m_set   = ((item.new_month >= 8'd1) && (item.new_month <= 8'(MONTHS_PER_YEAR)))
              ? item.new_month[3:0] : 4'd1;
    md_set  = month_days(m_set, leap_cand);
    m_step  = (mon_r >= MONTHS_PER_YEAR) ? 4'd1 : mon_r + 4'd1;
    md_step = month_days(m_step, leap_r);

    unique case (item.kind)
      KIND_TICK: begin
        if (!paused_r) begin
          if (sub_wide >= TPS) begin
            sub_nxt = '0;
            if (sec_r >= MINS_PER_HOUR - 6'd1) begin
              sec_nxt    = '0;
              chg_nxt[1] = 1'b1;
              if (min_r >= MINS_PER_HOUR - 6'd1) begin
                min_nxt    = '0;
                chg_nxt[0] = 1'b1;
                if (hour_r >= HOURS_PER_DAY - 5'd1) begin
                  hour_nxt   = '0;
                  chg_nxt[2] = 1'b1;
                  if (day_r >= md_cur) begin
                    day_nxt = 5'd1;
                    if (mon_r >= MONTHS_PER_YEAR) begin
                      mon_nxt  = 4'd1;
                      year_nxt = year_cand;
                      leap_nxt = leap_cand;
                    end else begin
                      mon_nxt = mon_r + 4'd1;
                    end
                  end else begin
                    day_nxt = day_r + 5'd1;
                  end
                end else begin
                  hour_nxt = hour_r + 5'd1;
                end
              end else begin
                min_nxt = min_r + 6'd1;
              end
              match     = (hour_nxt == alm_hour_r) && (min_nxt == alm_min_r);
              armed_tmp = armed_r || !match;
              if (alm_en_r && armed_tmp && match) begin
                fired_nxt = 1'b1;
                armed_nxt = 1'b0;
              end else begin
                armed_nxt = armed_tmp;
              end
            end else begin
              sec_nxt = sec_r + 6'd1;
            end
          end else begin
            sub_nxt = sub_wide[SUB_W-1:0];
          end
        end
      end
      KIND_SET_TIME: begin
        hour_nxt     = mod_hours(item.new_hour);
        min_nxt      = mod_minutes(item.new_minute);
        sec_nxt      = '0;
        sub_nxt      = '0;
        chg_nxt[1:0] = 2'b11;
      end
      KIND_SET_DATE: begin
        mon_nxt    = m_set;
        day_nxt    = ((item.new_day >= 8'd1) && (item.new_day <= {3'd0, md_set}))
                     ? item.new_day[4:0] : 5'd1;
        year_nxt   = item.new_year;
        leap_nxt   = leap_cand;
        chg_nxt[2] = 1'b1;
      end
      KIND_STEP_HOUR: begin
        hour_nxt   = (hour_r >= HOURS_PER_DAY - 5'd1) ? 5'd0 : hour_r + 5'd1;
        chg_nxt[0] = 1'b1;
      end
      KIND_STEP_MIN: begin
        min_nxt    = (min_r >= MINS_PER_HOUR - 6'd1) ? 6'd0 : min_r + 6'd1;
        chg_nxt[1] = 1'b1;
      end
      KIND_STEP_DAY: begin
        day_nxt    = (day_r >= md_cur) ? 5'd1 : day_r + 5'd1;
        chg_nxt[2] = 1'b1;
      end
      KIND_STEP_MONTH: begin
        mon_nxt    = m_step;
        day_nxt    = (day_r > md_step) ? md_step : day_r;
        chg_nxt[2] = 1'b1;
      end
      KIND_STEP_YEAR: begin
        year_nxt = year_step;
        leap_nxt = leap_step;
        if ((mon_r == MONTH_FEB) && (day_r == DAY_LEAP_FEB) && !leap_step) begin
          day_nxt = DAY_PLAIN_FEB;
        end
        chg_nxt[2] = 1'b1;
      end
      KIND_PAUSE: begin
        paused_nxt = 1'b1;
      end
      KIND_RESUME: begin
        paused_nxt = 1'b0;
        sub_nxt    = '0;
      end
      KIND_ACK: begin
        chg_nxt = chg_r & ~item.ack_mask[2:0];
        if (item.ack_mask[3]) fired_nxt = 1'b0;
      end
      KIND_DISMISS: begin
        armed_nxt = 1'b0;
        fired_nxt = 1'b0;
      end
      KIND_RESTART: begin
        sub_nxt    = '0;
        chg_nxt    = '0;
        fired_nxt  = 1'b0;
        paused_nxt = 1'b0;
        armed_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r    <= '0;
      sec_r    <= '0;
      min_r    <= '0;
      hour_r   <= RST_HOUR;
      day_r    <= 5'd1;
      mon_r    <= 4'd1;
      year_r   <= RST_YEAR;
      leap_r   <= 1'b0;
      chg_r    <= '0;
      fired_r  <= 1'b0;
      armed_r  <= 1'b1;
      paused_r <= 1'b0;
    end else if (fire) begin
      sub_r    <= sub_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hour_r   <= hour_nxt;
      day_r    <= day_nxt;
      mon_r    <= mon_nxt;
      year_r   <= year_nxt;
      leap_r   <= leap_nxt;
      chg_r    <= chg_nxt;
      fired_r  <= fired_nxt;
      armed_r  <= armed_nxt;
      paused_r <= paused_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alm_hour_r <= RST_ALARM_HOUR;
      alm_min_r  <= '0;
      alm_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_ALARM_HOUR:   alm_hour_r <= (cfg_wdata[4:0] < HOURS_PER_DAY) ? cfg_wdata[4:0] : 5'd0;
        CFG_ALARM_MINUTE: alm_min_r  <= (cfg_wdata < MINS_PER_HOUR) ? cfg_wdata : 6'd0;
        CFG_ALARM_ENABLE: alm_en_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign status_nxt.hour_now        = hour_nxt;
  assign status_nxt.minute_now      = min_nxt;
  assign status_nxt.second_now      = sec_nxt;
  assign status_nxt.day_now         = day_nxt;
  assign status_nxt.month_now       = mon_nxt;
  assign status_nxt.year_now        = year_nxt;
  assign status_nxt.hours_changed   = chg_nxt[0];
  assign status_nxt.minutes_changed = chg_nxt[1];
  assign status_nxt.date_changed    = chg_nxt[2];
  assign status_nxt.alarm_fired     = fired_nxt;
  assign status_nxt.is_paused       = paused_nxt;

  `RTC_ASSERT_NEXT(a_restart_clears, clk, rst_n, fire && (item.kind == KIND_RESTART),
    armed_r && !paused_r && !fired_r && (chg_r == 3'd0), "restart left flags set")
  `RTC_ASSERT_NEXT(a_pause_blocks_tick, clk, rst_n,
    fire && (item.kind == KIND_TICK) && paused_r, $stable(sub_r) && $stable(sec_r),
    "tick advanced while paused")
  `RTC_ASSERT_NEXT(a_idle_holds_time, clk, rst_n, !fire,
    $stable(sec_r) && $stable(min_r) && $stable(hour_r) && $stable(day_r) && $stable(year_r),
    "time changed without a request")
  `RTC_ASSERT_SAME(a_leap_tracks_year, clk, rst_n, 1'b1, leap_r == is_leap(year_r),
    "leap flag out of step with year")

endmodule

@@ rtl/core/rtc_out_stage.sv @@
// Result register stage: holds one status result until the receiver takes it.
module rtc_out_stage import rtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  status_t                status,
  output logic                   slot_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {1'b0, status.is_paused, status.alarm_fired, status.date_changed,
                 status.minutes_changed, status.hours_changed, status.year_now,
                 status.month_now, status.day_now, status.second_now,
                 status.minute_now, status.hour_now};
    end
  end

endmodule

@@ rtl/core/rtc_calendar_with_alarm.sv @@
// Top level of the real-time clock calendar with daily alarm.
//
// Requests arrive on the in_ stream: in_tuser carries the event kind (tick, set time,
// set date, step hour/minute/day/month/year, pause, resume, acknowledge, dismiss,
// restart), in_tdata the set values and the acknowledge mask. Every request yields
// exactly one result on the out_ stream: time, date, sticky change flags, the alarm
// flag and the pause state as they stand after that request.
// A request is registered on acceptance, processed in one pass of the carry chain
// once the output register is free, and its result is loaded into the output
// register, which raises out_tvalid. One request per cycle is sustained while
// out_tready stays high.
// The alarm registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while no request is in flight, which the block does not enforce.
// Reset (synchronous, active low) sets 12:00:00, 2025-01-01, alarm 07:00 disabled
// and armed, all flags clear. When out_tready is low the result is held and one
// more request may wait in the input register; in_tready then falls.
module rtc_calendar_with_alarm import rtc_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // new_hour, new_minute, new_day, new_month,
                                             // new_year, ack_mask, zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hour_now, minute_now, second_now, day_now,
                                             // month_now, year_now, hours_changed,
                                             // minutes_changed, date_changed,
                                             // alarm_fired, is_paused, zero pad
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic    item_valid;
  item_t   item;
  logic    slot_free;
  logic    fire;
  status_t status_nxt;

  assign fire = item_valid && slot_free;

  rtc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  rtc_engine #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .status_nxt (status_nxt)
  );

  rtc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .status     (status_nxt),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the RTC calendar with alarm: directed, rollover and random requests.
module testbench;
  import rtc_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned OUT_HOLD_CYCLES = 150;
  localparam int unsigned SECS_PER_MIN    = 60;
  localparam int unsigned RANDOM_CHUNKS   = 5;
  localparam int unsigned CHUNK_REQUESTS  = 45;

  localparam logic [3:0] KIND_SPARE_LO = 4'd13;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;

  localparam logic [2:0] FLAG_HOURS   = 3'b001;
  localparam logic [2:0] FLAG_MINUTES = 3'b010;
  localparam logic [2:0] FLAG_DATE    = 3'b100;
  localparam logic [3:0] ACK_ALARM    = 4'b1000;
  localparam logic [3:0] ACK_ALL      = 4'b1111;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  new_hour;
    logic [7:0]  new_minute;
    logic [7:0]  new_day;
    logic [7:0]  new_month;
    logic [15:0] new_year;
    logic [3:0]  ack_mask;
  } rtc_req_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // new_hour, new_minute, new_day, new_month, new_year,
                                      // ack_mask, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // hour_now, minute_now, second_now, day_now, month_now,
                                      // year_now, hours_changed, minutes_changed,
                                      // date_changed, alarm_fired, is_paused, zero pad
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  rtc_calendar_with_alarm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predicted clock state
  logic [9:0]  ms_count;
  logic [5:0]  sec_r, min_r;
  logic [4:0]  hr_r, day_r;
  logic [3:0]  mon_r;
  logic [15:0] yr_r;
  logic [2:0]  chg_r;
  logic        fired_r, armed_r, paused_r;
  logic [4:0]  alarm_hr;
  logic [5:0]  alarm_min;
  logic        alarm_en;

  status_t pending_status_q[$];
  int      err_count = 0;
  int      stall_cycles = 0;
  bit      idle_on = 1'b1;
  bit      hold_out_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_leap(logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [4:0] month_length(logic [3:0] m, logic [15:0] y);
    case (m)
      MONTH_FEB:               return is_leap(y) ? DAY_LEAP_FEB : DAY_PLAIN_FEB;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic void clear_clock();
    alarm_hr = RST_ALARM_HOUR; alarm_min = '0; alarm_en = 1'b0;
    ms_count = '0; sec_r = '0; min_r = '0; hr_r = RST_HOUR;
    day_r = 5'd1; mon_r = 4'd1; yr_r = RST_YEAR;
    chg_r = '0; fired_r = 1'b0; armed_r = 1'b1; paused_r = 1'b0;
  endfunction

  // one second elapsed; minute/hour/date carry, then re-arm and alarm match
  function automatic void advance_second();
    if (sec_r != SECS_PER_MIN - 1) begin
      sec_r++;
      return;
    end
    sec_r = '0;
    chg_r |= FLAG_MINUTES;
    if (min_r != MINS_PER_HOUR - 1) begin
      min_r++;
    end else begin
      min_r = '0;
      hr_r = (hr_r == HOURS_PER_DAY - 1) ? 5'd0 : hr_r + 5'd1;
      chg_r |= FLAG_HOURS;
      if (hr_r == 0) begin
        chg_r |= FLAG_DATE;
        if (day_r < month_length(mon_r, yr_r)) begin
          day_r++;
        end else begin
          day_r = 5'd1;
          if (mon_r < MONTHS_PER_YEAR) begin
            mon_r++;
          end else begin
            mon_r = 4'd1;
            yr_r++;
          end
        end
      end
    end
    if (!armed_r && (hr_r != alarm_hr || min_r != alarm_min)) armed_r = 1'b1;
    if (alarm_en && armed_r && hr_r == alarm_hr && min_r == alarm_min) begin
      fired_r = 1'b1;
      armed_r = 1'b0;
    end
  endfunction

  function automatic status_t apply_event(rtc_req_t r);
    status_t     s;
    logic [4:0]  md;
    case (r.kind)
      KIND_TICK: begin
        if (!paused_r) begin
          if (ms_count + 1 >= DEF_TICKS_PER_SECOND) begin
            ms_count = '0;
            advance_second();
          end else begin
            ms_count++;
          end
        end
      end
      KIND_SET_TIME: begin
        hr_r = 5'(r.new_hour % HOURS_PER_DAY);
        min_r = 6'(r.new_minute % MINS_PER_HOUR);
        sec_r = '0;
        ms_count = '0;
        chg_r |= FLAG_HOURS | FLAG_MINUTES;
      end
      KIND_SET_DATE: begin
        mon_r = (r.new_month >= 1 && r.new_month <= MONTHS_PER_YEAR) ? r.new_month[3:0] : 4'd1;
        md = month_length(mon_r, r.new_year);
        day_r = (r.new_day >= 1 && r.new_day <= md) ? r.new_day[4:0] : 5'd1;
        yr_r = r.new_year;
        chg_r |= FLAG_DATE;
      end
      KIND_STEP_HOUR: begin
        hr_r = (hr_r == HOURS_PER_DAY - 1) ? 5'd0 : hr_r + 5'd1;
        chg_r |= FLAG_HOURS;
      end
      KIND_STEP_MIN: begin
        min_r = (min_r == MINS_PER_HOUR - 1) ? 6'd0 : min_r + 6'd1;
        chg_r |= FLAG_MINUTES;
      end
      KIND_STEP_DAY: begin
        md = month_length(mon_r, yr_r);
        day_r = (day_r % md) + 5'd1;
        chg_r |= FLAG_DATE;
      end
      KIND_STEP_MONTH: begin
        mon_r = (mon_r % MONTHS_PER_YEAR) + 4'd1;
        md = month_length(mon_r, yr_r);
        if (day_r > md) day_r = md;
        chg_r |= FLAG_DATE;
      end
      KIND_STEP_YEAR: begin
        if (yr_r < YEAR_STEP_MAX) yr_r++;
        if (mon_r == MONTH_FEB && day_r == DAY_LEAP_FEB && !is_leap(yr_r)) day_r = DAY_PLAIN_FEB;
        chg_r |= FLAG_DATE;
      end
      KIND_PAUSE: paused_r = 1'b1;
      KIND_RESUME: begin
        paused_r = 1'b0;
        ms_count = '0;
      end
      KIND_ACK: begin
        chg_r &= ~r.ack_mask[2:0];
        if (r.ack_mask[3]) fired_r = 1'b0;
      end
      KIND_DISMISS: begin
        armed_r = 1'b0;
        fired_r = 1'b0;
      end
      KIND_RESTART: begin
        ms_count = '0;
        chg_r = '0;
        fired_r = 1'b0;
        paused_r = 1'b0;
        armed_r = 1'b1;
      end
      default: ;
    endcase
    s.hour_now        = hr_r;
    s.minute_now      = min_r;
    s.second_now      = sec_r;
    s.day_now         = day_r;
    s.month_now       = mon_r;
    s.year_now        = yr_r;
    s.hours_changed   = chg_r[0];
    s.minutes_changed = chg_r[1];
    s.date_changed    = chg_r[2];
    s.alarm_fired     = fired_r;
    s.is_paused       = paused_r;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: unrequested result, expected none actual %h", $time, out_tdata);
        err_count++;
      end else begin
        want = pending_status_q.pop_front();
        check_field("hour_now",        want.hour_now,        out_tdata[4:0]);
        check_field("minute_now",      want.minute_now,      out_tdata[10:5]);
        check_field("second_now",      want.second_now,      out_tdata[16:11]);
        check_field("day_now",         want.day_now,         out_tdata[21:17]);
        check_field("month_now",       want.month_now,       out_tdata[25:22]);
        check_field("year_now",        want.year_now,        out_tdata[41:26]);
        check_field("hours_changed",   want.hours_changed,   out_tdata[42]);
        check_field("minutes_changed", want.minutes_changed, out_tdata[43]);
        check_field("date_changed",    want.date_changed,    out_tdata[44]);
        check_field("alarm_fired",     want.alarm_fired,     out_tdata[45]);
        check_field("is_paused",       want.is_paused,       out_tdata[46]);
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result receiver
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_tready <= 1'b0;
        repeat (OUT_HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(rtc_req_t r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {4'd0, r.ack_mask, r.new_year, r.new_month, r.new_day,
                  r.new_minute, r.new_hour};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status_q.push_back(apply_event(r));
  endtask

  function automatic rtc_req_t rand_req(logic [3:0] kind);
    rtc_req_t r;
    r.kind       = kind;
    r.new_hour   = 8'($urandom);
    r.new_minute = 8'($urandom);
    r.new_day    = 8'($urandom);
    r.new_month  = 8'($urandom);
    r.new_year   = 16'($urandom);
    r.ack_mask   = 4'($urandom);
    return r;
  endfunction

  task automatic send_kind(logic [3:0] kind);
    send_request(rand_req(kind));
  endtask

  task automatic set_time(logic [7:0] h, logic [7:0] m);
    rtc_req_t r;
    r = rand_req(KIND_SET_TIME);
    r.new_hour = h;
    r.new_minute = m;
    send_request(r);
  endtask

  task automatic set_date(logic [7:0] d, logic [7:0] mo, logic [15:0] y);
    rtc_req_t r;
    r = rand_req(KIND_SET_DATE);
    r.new_day = d;
    r.new_month = mo;
    r.new_year = y;
    send_request(r);
  endtask

  task automatic send_ack(logic [3:0] mask);
    rtc_req_t r;
    r = rand_req(KIND_ACK);
    r.ack_mask = mask;
    send_request(r);
  endtask

  task automatic run_ticks(int unsigned n);
    repeat (n) send_kind(KIND_TICK);
  endtask

  task automatic send_random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) send_kind(KIND_TICK);
    else if (pick < 55) send_kind(KIND_SET_TIME);
    else if (pick < 62) set_date(8'($urandom_range(1, 31)), 8'($urandom_range(1, 12)),
                                 16'($urandom_range(0, 1) ? $urandom_range(1896, 2104)
                                                          : $urandom));
    else if (pick < 65) send_kind(KIND_SET_DATE);
    else send_kind(4'($urandom_range(KIND_STEP_HOUR, KIND_SPARE_HI)));
  endtask

  // wait until every request has its result, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALARM_HOUR:   alarm_hr  = (value[4:0] < HOURS_PER_DAY) ? value[4:0] : 5'd0;
      CFG_ALARM_MINUTE: alarm_min = (value < MINS_PER_HOUR) ? value : 6'd0;
      CFG_ALARM_ENABLE: alarm_en  = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_set_and_step();
    send_kind(KIND_SPARE_HI);
    set_time(8'd255, 8'd255);
    set_time(8'd0, 8'd0);
    set_time(8'd23, 8'd59);
    send_kind(KIND_STEP_HOUR);
    send_kind(KIND_STEP_MIN);
    set_date(8'd0, 8'd0, 16'hFFFF);
    set_date(8'd31, 8'd12, 16'd2024);
    send_kind(KIND_STEP_DAY);
    send_kind(KIND_STEP_MONTH);
    set_date(8'd31, 8'd1, 16'd2024);
    send_kind(KIND_STEP_MONTH);
    send_kind(KIND_STEP_YEAR);
    set_date(8'd29, 8'd2, 16'd2023);
    set_date(8'd29, 8'd2, 16'd0);
    set_date(8'd29, 8'd2, 16'd2100);
    set_date(8'd255, 8'd255, 16'd2099);
    send_kind(KIND_STEP_YEAR);
  endtask

  task automatic test_control_events();
    send_kind(KIND_PAUSE);
    run_ticks(3);
    send_kind(KIND_STEP_HOUR);
    send_kind(KIND_RESUME);
    run_ticks(2);
    send_ack(ACK_ALL);
    send_kind(KIND_DISMISS);
    send_ack(4'd0);
    send_kind(KIND_RESTART);
    send_kind(KIND_SPARE_LO);
  endtask

  task automatic test_alarm_and_rollover();
    idle_on = 1'b0;
    settle();
    write_reg(CFG_ALARM_HOUR, 6'd56);    // low bits give 24: stored as 0
    write_reg(CFG_ALARM_MINUTE, 6'd63);  // stored as 0
    write_reg(CFG_ALARM_ENABLE, 6'd1);
    send_kind(KIND_RESTART);
    // one full second of ticks at the last minute of the last year
    set_date(8'd31, 8'd12, 16'hFFFF);
    set_time(8'd23, 8'd59);
    run_ticks(DEF_TICKS_PER_SECOND);
    send_ack(ACK_ALARM);
    send_kind(KIND_DISMISS);
    settle();
    write_reg(CFG_ALARM_ENABLE, 6'd0);
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_out_req = 1'b1;
    repeat (40) send_random_event();
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_random_event();
    settle();
    repeat (20) send_random_event();
  endtask

  task automatic test_random_events();
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      settle();
      write_reg(CFG_ALARM_HOUR, 6'($urandom));
      write_reg(CFG_ALARM_MINUTE, 6'($urandom));
      write_reg(CFG_ALARM_ENABLE, 6'($urandom));
      if (chunk == RANDOM_CHUNKS - 1) idle_on = 1'b0;
      repeat (CHUNK_REQUESTS) begin
        if ($urandom_range(0, 39) == 0) run_ticks($urandom_range(5, 40));
        else send_random_event();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    clear_clock();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_set_and_step();
    test_control_events();
    test_alarm_and_rollover();
    test_output_stall();
    test_sender_pause();
    test_random_events();
    settle();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rtc_pkg.sv
rtl/core/rtc_in_stage.sv
rtl/core/rtc_engine.sv
rtl/core/rtc_out_stage.sv
rtl/core/rtc_calendar_with_alarm.sv
tb/testbench.sv
